### hdl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is asserted.
`define RSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, but also evaluated during reset.
`define RSA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// Register slot allocator package
// Request/result types, mode and kind codes, back-end state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

	localparam logic [2:0] MODE_SRC    = 3'd0;
	localparam logic [2:0] MODE_DST    = 3'd1;
	localparam logic [2:0] MODE_BLK_ST = 3'd2;
	localparam logic [2:0] MODE_BLK_END = 3'd3;
	localparam logic [2:0] MODE_FN_ST  = 3'd4;

	localparam logic [1:0] KIND_GRANT  = 2'd0;
	localparam logic [1:0] KIND_STORE  = 2'd1;
	localparam logic [1:0] KIND_RELOAD = 2'd2;
	localparam logic [1:0] KIND_ACK    = 2'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] vreg;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         slot;
		logic [7:0]         slot_vreg;
		logic signed [11:0] frame_offset;
		logic               offset_known;
		logic               last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FL_SCAN,
		ST_ST_RD,
		ST_ST_EMIT,
		ST_RLD_RD,
		ST_RLD_EMIT,
		ST_GRANT
	} back_state_t;

	// -4 * (idx + 4), modulo 2^12
	function automatic logic signed [11:0] frame_ofs(input logic [11:0] idx);
		logic [11:0] t;
		t = (idx + 12'd4) << 2;
		return signed'(12'd0 - t);
	endfunction

endpackage

`default_nettype wire

### hdl/rsa_front.sv
// ----------------------------------------------------------------------------
// Register slot allocator request queue
// Two-entry FIFO between the command port and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rsa_pkg::req_t request,
	output logic               busy,
	input  wire logic          pop,
	output logic               empty,
	output rsa_pkg::req_t      head
);

	rsa_pkg::req_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          do_pop;

	assign busy   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign push   = start && !busy;
	assign do_pop = pop && !empty;
	assign head   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/rsa_back.sv
// ----------------------------------------------------------------------------
// Register slot allocator executor
// Slot lookup, replacement, spill-offset table and result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_back #(
	parameter int SLOT_COUNT = 8,
	parameter int VREG_BITS  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire rsa_pkg::req_t head,
	output logic               pop,
	output logic               result_valid,
	output rsa_pkg::res_t      result
);

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int VSPAN = 1 << VREG_BITS;

	rsa_pkg::back_state_t state_q, state_d;

	logic [2:0]           mode_q;
	logic [VREG_BITS-1:0] v_q;
	logic [SLOT_COUNT-1:0] valid_q, dirty_q;
	logic [VREG_BITS-1:0] tag_q [SLOT_COUNT];
	logic [SW-1:0]        vp_q;
	logic [SW-1:0]        slot_q;
	logic [SW-1:0]        fl_ptr_q;
	logic [VREG_BITS-1:0] st_tag_q;
	logic                 st_last_q;
	logic [VSPAN-1:0]     known_q;
	logic [VREG_BITS:0]   count_q;
	logic [VREG_BITS-1:0] spill_mem [VSPAN];
	logic [VREG_BITS-1:0] rdata_q;
	logic [VREG_BITS-1:0] rd_addr;

	// lookup / replacement search
	logic          hit, has_empty, has_clean, any_dirty, fl_more;
	logic [SW-1:0] hit_idx, empty_idx, clean_idx, fl_idx, take_idx;
	logic          take_victim;

	always_comb begin
		hit = 1'b0; hit_idx = '0;
		has_empty = 1'b0; empty_idx = '0;
		has_clean = 1'b0; clean_idx = '0;
		fl_idx = '0;
		fl_more = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == v_q) begin
				hit = 1'b1; hit_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				has_empty = 1'b1; empty_idx = SW'(i);
			end
			if (!dirty_q[i]) begin
				has_clean = 1'b1; clean_idx = SW'(i);
			end
			if (dirty_q[i] && SW'(i) >= fl_ptr_q) begin
				fl_idx = SW'(i);
			end
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (dirty_q[i] && SW'(i) > fl_idx) begin
				fl_more = 1'b1;
			end
		end
		any_dirty   = |dirty_q;
		take_victim = !has_empty && !has_clean;
		take_idx    = has_empty ? empty_idx : (has_clean ? clean_idx : vp_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsa_pkg::ST_IDLE: begin
				if (!empty) state_d = rsa_pkg::ST_DECIDE;
			end
			rsa_pkg::ST_DECIDE: begin
				case (mode_q)
					rsa_pkg::MODE_SRC: begin
						if (hit) state_d = rsa_pkg::ST_IDLE;
						else if (take_victim) state_d = rsa_pkg::ST_ST_RD;
						else state_d = rsa_pkg::ST_RLD_RD;
					end
					rsa_pkg::MODE_DST: begin
						if (!hit && take_victim) state_d = rsa_pkg::ST_ST_RD;
						else state_d = rsa_pkg::ST_IDLE;
					end
					rsa_pkg::MODE_BLK_END: begin
						state_d = any_dirty ? rsa_pkg::ST_FL_SCAN : rsa_pkg::ST_IDLE;
					end
					default: state_d = rsa_pkg::ST_IDLE;
				endcase
			end
			rsa_pkg::ST_FL_SCAN: state_d = rsa_pkg::ST_ST_RD;
			rsa_pkg::ST_ST_RD:   state_d = rsa_pkg::ST_ST_EMIT;
			rsa_pkg::ST_ST_EMIT: begin
				case (mode_q)
					rsa_pkg::MODE_SRC: state_d = rsa_pkg::ST_RLD_RD;
					rsa_pkg::MODE_DST: state_d = rsa_pkg::ST_GRANT;
					default: state_d = st_last_q ? rsa_pkg::ST_IDLE : rsa_pkg::ST_FL_SCAN;
				endcase
			end
			rsa_pkg::ST_RLD_RD:   state_d = rsa_pkg::ST_RLD_EMIT;
			rsa_pkg::ST_RLD_EMIT: state_d = rsa_pkg::ST_IDLE;
			rsa_pkg::ST_GRANT:    state_d = rsa_pkg::ST_IDLE;
			default:              state_d = rsa_pkg::ST_IDLE;
		endcase
	end

	// outputs
	logic          emit;
	rsa_pkg::res_t res_d;
	logic          st_known, rl_known;

	assign st_known = known_q[st_tag_q];
	assign rl_known = known_q[v_q];
	assign pop      = (state_q == rsa_pkg::ST_IDLE) && !empty;
	assign rd_addr  = (state_q == rsa_pkg::ST_RLD_RD) ? v_q : st_tag_q;

	always_comb begin
		emit  = 1'b0;
		res_d = '{kind: rsa_pkg::KIND_ACK, slot: 3'd0, slot_vreg: 8'd0,
		          frame_offset: 12'sd0, offset_known: 1'b1, last: 1'b1};
		case (state_q)
			rsa_pkg::ST_DECIDE: begin
				case (mode_q)
					rsa_pkg::MODE_SRC: begin
						emit = hit;
						res_d.kind = rsa_pkg::KIND_GRANT;
						res_d.slot = 3'(hit_idx);
						res_d.slot_vreg = 8'(v_q);
					end
					rsa_pkg::MODE_DST: begin
						emit = hit || !take_victim;
						res_d.kind = rsa_pkg::KIND_GRANT;
						res_d.slot = 3'(hit ? hit_idx : take_idx);
						res_d.slot_vreg = 8'(v_q);
					end
					rsa_pkg::MODE_BLK_END: emit = !any_dirty;
					default:               emit = 1'b1;
				endcase
			end
			rsa_pkg::ST_ST_EMIT: begin
				emit = 1'b1;
				res_d.kind = rsa_pkg::KIND_STORE;
				res_d.slot = 3'(slot_q);
				res_d.slot_vreg = 8'(st_tag_q);
				res_d.frame_offset = rsa_pkg::frame_ofs(
					st_known ? 12'(rdata_q) : 12'(count_q));
				res_d.last = st_last_q;
			end
			rsa_pkg::ST_RLD_EMIT: begin
				emit = 1'b1;
				res_d.kind = rsa_pkg::KIND_RELOAD;
				res_d.slot = 3'(slot_q);
				res_d.slot_vreg = 8'(v_q);
				res_d.frame_offset = rl_known ? rsa_pkg::frame_ofs(12'(rdata_q)) : 12'sd0;
				res_d.offset_known = rl_known;
			end
			rsa_pkg::ST_GRANT: begin
				emit = 1'b1;
				res_d.kind = rsa_pkg::KIND_GRANT;
				res_d.slot = 3'(slot_q);
				res_d.slot_vreg = 8'(v_q);
			end
			default: emit = 1'b0;
		endcase
	end

	// spill-offset memory
	always_ff @(posedge clk) begin
		if (state_q == rsa_pkg::ST_ST_EMIT && !st_known) begin
			spill_mem[st_tag_q] <= count_q[VREG_BITS-1:0];
		end
		rdata_q <= spill_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		result <= res_d;
		if (pop) begin
			mode_q <= head.mode;
			v_q    <= VREG_BITS'(head.vreg);
		end
		if (state_q == rsa_pkg::ST_DECIDE) begin
			slot_q    <= take_idx;
			st_tag_q  <= tag_q[vp_q];
			st_last_q <= 1'b0;
		end
		if (state_q == rsa_pkg::ST_FL_SCAN) begin
			slot_q    <= fl_idx;
			st_tag_q  <= tag_q[fl_idx];
			st_last_q <= !fl_more;
		end
	end

	// control and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rsa_pkg::ST_IDLE;
			result_valid <= 1'b0;
			valid_q      <= '0;
			dirty_q      <= '0;
			vp_q         <= '0;
			fl_ptr_q     <= '0;
			known_q      <= '0;
			count_q      <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) tag_q[i] <= '0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			case (state_q)
				rsa_pkg::ST_DECIDE: begin
					fl_ptr_q <= '0;
					case (mode_q)
						rsa_pkg::MODE_SRC: begin
							if (!hit && take_victim) begin
								vp_q <= (vp_q == SW'(SLOT_COUNT - 1)) ? '0 : vp_q + 1'b1;
								dirty_q[vp_q] <= 1'b0;
								valid_q[vp_q] <= 1'b0;
							end
						end
						rsa_pkg::MODE_DST: begin
							if (hit) begin
								dirty_q[hit_idx] <= 1'b1;
							end else if (take_victim) begin
								vp_q <= (vp_q == SW'(SLOT_COUNT - 1)) ? '0 : vp_q + 1'b1;
								dirty_q[vp_q] <= 1'b0;
								valid_q[vp_q] <= 1'b0;
							end else begin
								tag_q[take_idx]   <= v_q;
								valid_q[take_idx] <= 1'b1;
								dirty_q[take_idx] <= 1'b1;
							end
						end
						rsa_pkg::MODE_BLK_ST: begin
							valid_q <= '0;
							dirty_q <= '0;
						end
						rsa_pkg::MODE_FN_ST: begin
							known_q <= '0;
							count_q <= '0;
							vp_q    <= '0;
						end
						default: ;
					endcase
				end
				rsa_pkg::ST_FL_SCAN: fl_ptr_q <= fl_idx + 1'b1;
				rsa_pkg::ST_ST_EMIT: begin
					if (!st_known) begin
						known_q[st_tag_q] <= 1'b1;
						count_q           <= count_q + 1'b1;
					end
				end
				rsa_pkg::ST_RLD_EMIT: begin
					tag_q[slot_q]   <= v_q;
					valid_q[slot_q] <= 1'b1;
				end
				rsa_pkg::ST_GRANT: begin
					tag_q[slot_q]   <= v_q;
					valid_q[slot_q] <= 1'b1;
					dirty_q[slot_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/register_slot_allocator.sv
// ----------------------------------------------------------------------------
// Register slot allocator
// Fully associative register slots run as a write-back cache of vregs.
// ----------------------------------------------------------------------------
//
//  channel   | signals                     | handshake
//  ----------+-----------------------------+---------------------------------
//  request   | request.{mode,vreg}         | taken when start && !busy
//  result    | result.{kind,slot,...,last} | one cycle, marked by result_valid
//
// A request on a hit, grant or acknowledge passes the executor's idle and
// decide states; each spill store adds a state for the offset table read,
// then an emit state, a reload adds the same pair, a destination that spills
// adds a grant state, and a block-end flush runs scan, read and emit states
// per dirty slot, all set by the executor state machine.
// A two-entry queue absorbs requests while the executor works; busy is high
// only while that queue is full. Results cannot be stalled.
// Reset clears all slots, the victim pointer, the spill table known bits and
// the spill count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_slot_allocator #(
	parameter int SLOT_COUNT = 8,
	parameter int VREG_BITS  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rsa_pkg::req_t request,
	output logic               busy,
	output logic               result_valid,
	output rsa_pkg::res_t      result
);

	logic          q_empty;
	logic          q_pop;
	rsa_pkg::req_t q_head;

	// front: request queue
	rsa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	// back: slot lookup, replacement, spill/reload sequencing
	rsa_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.VREG_BITS  (VREG_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

### hdl/rsa_checker.sv
// ----------------------------------------------------------------------------
// Register slot allocator port checker
// Watches the top-level ports for result-coding and queue-flow slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          result_valid,
	input wire rsa_pkg::res_t result
);

	`RSA_ASSERT(a_ack_last, result_valid && result.kind == rsa_pkg::KIND_ACK |-> result.last, "ack not last")
	`RSA_ASSERT(a_reload_last, result_valid && result.kind == rsa_pkg::KIND_RELOAD |-> result.last, "reload not last")
	`RSA_ASSERT(a_grant_clean, result_valid && result.kind == rsa_pkg::KIND_GRANT |-> result.frame_offset == 12'sd0 && result.offset_known, "bad grant")
	`RSA_ASSERT(a_busy_rise, $rose(busy) |-> $past(start), "busy without request")
	`RSA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid || arst_n, "result during reset")

endmodule

bind register_slot_allocator rsa_checker u_rsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Register slot allocator testbench
// Drives source, destination, block and function requests, predicts every
// grant, spill store, reload and acknowledge, and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	localparam int NSLOT = 8;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	rsa_pkg::req_t request = '0;
	logic          busy;
	logic          result_valid;
	rsa_pkg::res_t result;

	register_slot_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .result_valid(result_valid), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the allocator state
	logic       sh_valid [NSLOT];
	logic       sh_dirty [NSLOT];
	logic [7:0] sh_tag [NSLOT];
	logic [2:0] sh_victim;
	logic       sh_known [256];
	logic [7:0] sh_index [256];
	logic [8:0] sh_count;

	rsa_pkg::res_t expected_results[$];
	int   mismatches = 0;
	int   n_results = 0;
	int   n_stores = 0;
	int   n_reloads = 0;
	int   n_requests = 0;

	function automatic logic signed [11:0] spill_ofs(input logic [7:0] idx);
		logic [11:0] t;
		t = ({4'd0, idx} + 12'd4) * 12'd4;
		return signed'(12'd0 - t);
	endfunction

	function automatic rsa_pkg::res_t mk(input logic [1:0] k, input logic [2:0] s,
			input logic [7:0] v, input logic signed [11:0] o, input logic kn);
		rsa_pkg::res_t r;
		r.kind = k; r.slot = s; r.slot_vreg = v;
		r.frame_offset = o; r.offset_known = kn; r.last = 1'b0;
		return r;
	endfunction

	// Append one predicted result.
	function automatic void expect_result(input rsa_pkg::res_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic void clear_shadow();
		for (int i = 0; i < NSLOT; i++) begin
			sh_valid[i] = 0; sh_dirty[i] = 0; sh_tag[i] = '0;
		end
		for (int i = 0; i < 256; i++) sh_known[i] = 0;
		sh_victim = '0;
		sh_count = '0;
	endfunction

	function automatic void queue_store(input int s);
		logic [7:0] v;
		v = sh_tag[s];
		if (!sh_known[v]) begin
			sh_known[v] = 1;
			sh_index[v] = sh_count[7:0];
			sh_count++;
		end
		expect_result(mk(rsa_pkg::KIND_STORE, s[2:0], v, spill_ofs(sh_index[v]), 1'b1));
	endfunction

	// Empty slot first, then clean, then round-robin dirty victim (spilled).
	function automatic int pick_slot();
		int s;
		for (int i = 0; i < NSLOT; i++)
			if (!sh_valid[i]) return i;
		for (int i = 0; i < NSLOT; i++)
			if (!sh_dirty[i]) begin
				sh_valid[i] = 0;
				return i;
			end
		s = sh_victim;
		sh_victim = sh_victim + 3'd1;
		queue_store(s);
		sh_dirty[s] = 0;
		sh_valid[s] = 0;
		return s;
	endfunction

	function automatic int lookup(input logic [7:0] v);
		for (int i = 0; i < NSLOT; i++)
			if (sh_valid[i] && sh_tag[i] == v) return i;
		return -1;
	endfunction

	function automatic void predict_allocation(input rsa_pkg::req_t rq);
		int first, hit, s;
		first = expected_results.size();
		case (rq.mode)
			rsa_pkg::MODE_SRC: begin
				hit = lookup(rq.vreg);
				if (hit >= 0) begin
					expect_result(mk(rsa_pkg::KIND_GRANT, hit[2:0], rq.vreg, '0, 1'b1));
				end else begin
					s = pick_slot();
					if (sh_known[rq.vreg])
						expect_result(mk(rsa_pkg::KIND_RELOAD, s[2:0], rq.vreg,
							spill_ofs(sh_index[rq.vreg]), 1'b1));
					else
						expect_result(mk(rsa_pkg::KIND_RELOAD, s[2:0], rq.vreg, '0, 1'b0));
					sh_tag[s] = rq.vreg;
					sh_valid[s] = 1;
				end
			end
			rsa_pkg::MODE_DST: begin
				hit = lookup(rq.vreg);
				s = (hit >= 0) ? hit : pick_slot();
				sh_tag[s] = rq.vreg;
				sh_valid[s] = 1;
				sh_dirty[s] = 1;
				expect_result(mk(rsa_pkg::KIND_GRANT, s[2:0], rq.vreg, '0, 1'b1));
			end
			rsa_pkg::MODE_BLK_ST: begin
				for (int i = 0; i < NSLOT; i++) begin
					sh_valid[i] = 0; sh_dirty[i] = 0;
				end
				expect_result(mk(rsa_pkg::KIND_ACK, '0, '0, '0, 1'b1));
			end
			rsa_pkg::MODE_BLK_END: begin
				for (int i = 0; i < NSLOT; i++)
					if (sh_dirty[i]) queue_store(i);
				if (expected_results.size() == first)
					expect_result(mk(rsa_pkg::KIND_ACK, '0, '0, '0, 1'b1));
			end
			rsa_pkg::MODE_FN_ST: begin
				for (int i = 0; i < 256; i++) sh_known[i] = 0;
				sh_count = '0;
				sh_victim = '0;
				expect_result(mk(rsa_pkg::KIND_ACK, '0, '0, '0, 1'b1));
			end
			default: expect_result(mk(rsa_pkg::KIND_ACK, '0, '0, '0, 1'b1));
		endcase
		expected_results[$].last = 1'b1;
	endfunction

	// Sender burst/gap shaping
	int burst_left = 0;
	bit no_gaps = 0;

	task automatic send_request(input logic [2:0] m, input logic [7:0] v);
		rsa_pkg::req_t rq;
		int gap;
		gap = 0;
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		rq.mode = m;
		rq.vreg = v;
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		predict_allocation(rq);
		n_requests++;
	endtask

	task automatic drain();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (expected_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		rsa_pkg::res_t want;
		if (arst_n && result_valid) begin
			n_results++;
			if (result.kind == rsa_pkg::KIND_STORE) n_stores++;
			if (result.kind == rsa_pkg::KIND_RELOAD) n_reloads++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", result);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result mismatch expected %p got %p", want, result);
				end
			end
		end
	end

	// Directed: acknowledges, unused modes, field extremes.
	task automatic test_control_modes();
		send_request(rsa_pkg::MODE_BLK_END, 8'd0);
		send_request(rsa_pkg::MODE_BLK_ST, 8'hFF);
		send_request(rsa_pkg::MODE_FN_ST, 8'h55);
		send_request(3'd5, 8'hAA);
		send_request(3'd6, 8'd0);
		send_request(3'd7, 8'hFF);
	endtask

	// Directed: hits, misses, never-spilled reload, victim spill, flush.
	task automatic test_directed_alloc();
		send_request(rsa_pkg::MODE_SRC, 8'd0);
		send_request(rsa_pkg::MODE_SRC, 8'd0);
		send_request(rsa_pkg::MODE_DST, 8'hFF);
		send_request(rsa_pkg::MODE_DST, 8'hFF);
		for (int i = 1; i <= 8; i++) send_request(rsa_pkg::MODE_DST, 8'(i * 17));
		send_request(rsa_pkg::MODE_SRC, 8'hFF);
		send_request(rsa_pkg::MODE_BLK_END, 8'd0);
		send_request(rsa_pkg::MODE_BLK_ST, 8'd0);
		send_request(rsa_pkg::MODE_SRC, 8'd17);
		send_request(rsa_pkg::MODE_FN_ST, 8'd0);
		send_request(rsa_pkg::MODE_SRC, 8'd34);
		send_request(rsa_pkg::MODE_BLK_ST, 8'd0);
	endtask

	// Random: mostly well-formed blocks over a small vreg pool to force
	// hits, spills and reloads; some full-range noise.
	task automatic test_random_blocks(input int count);
		int sent, pool, r;
		logic [7:0] v;
		sent = 0;
		while (sent < count) begin
			pool = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(6, 20);
			if ($urandom_range(0, 4) == 0) begin
				send_request(rsa_pkg::MODE_FN_ST, 8'($urandom));
				sent++;
			end
			send_request(rsa_pkg::MODE_BLK_ST, 8'($urandom));
			sent++;
			repeat ($urandom_range(4, 20)) begin
				r = $urandom_range(0, 99);
				v = (pool == 255) ? 8'($urandom) : 8'($urandom_range(0, pool) + 8'd240);
				if (r < 45) send_request(rsa_pkg::MODE_SRC, v);
				else if (r < 90) send_request(rsa_pkg::MODE_DST, v);
				else if (r < 95) send_request(rsa_pkg::MODE_BLK_END, v);
				else send_request(3'($urandom_range(2, 7)), v);
				sent++;
			end
			send_request(rsa_pkg::MODE_BLK_END, 8'($urandom));
			sent++;
			if ($urandom_range(0, 3) == 0) begin
				no_gaps = ~no_gaps;
				burst_left = 0;
			end
		end
	endtask

	initial begin
		clear_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_control_modes();
		test_directed_alloc();
		// wait for every expected result before going on
		drain();
		test_random_blocks(170);
		drain();
		test_random_blocks(160);
		drain();
		if (expected_results.size() != 0) mismatches++;
		$display("Ran %0d requests: %0d results, %0d spill stores, %0d reloads.",
			n_requests, n_results, n_stores, n_reloads);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
